FILE: hw/rtl/mcr_pkg.sv
package mcr_pkg;

	// Coordinate and field widths
	localparam int unsigned COORD_BITS  = 12;
	localparam int unsigned RADIUS_BITS = 6;
	localparam int unsigned STEP_BITS   = 6;
	localparam int unsigned DEC_BITS    = 10;
	localparam int unsigned POINT_BITS  = 2 * COORD_BITS;

	// Largest radius taken as is; larger requests saturate
	localparam logic [RADIUS_BITS-1:0] MAX_RADIUS = RADIUS_BITS'(63);
	// Most loop sets one circle may emit before the closing set
	localparam logic [STEP_BITS-1:0] MAX_SETS = STEP_BITS'(46);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic [RADIUS_BITS-1:0]       radius;
	} req_t;

	typedef struct packed {
		logic [POINT_BITS-1:0] point_0;
		logic [POINT_BITS-1:0] point_1;
		logic [POINT_BITS-1:0] point_2;
		logic [POINT_BITS-1:0] point_3;
		logic [POINT_BITS-1:0] point_4;
		logic [POINT_BITS-1:0] point_5;
		logic [POINT_BITS-1:0] point_6;
		logic [POINT_BITS-1:0] point_7;
		logic                  last;
	} pts_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic more;
	} dp_status_t;

endpackage

FILE: hw/rtl/mcr_dp.sv
module mcr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mcr_pkg::req_t      req,
	input  mcr_pkg::dp_cmd_t   cmd,
	output mcr_pkg::dp_status_t status,
	output mcr_pkg::pts_t      pts
);

	localparam int unsigned CW = mcr_pkg::COORD_BITS;
	localparam int unsigned SW = mcr_pkg::STEP_BITS;
	localparam int unsigned DW = mcr_pkg::DEC_BITS;

	logic [SW-1:0]          x_q;
	logic [SW-1:0]          y_q;
	logic signed [DW-1:0]   d_q;
	logic [CW-1:0]          cx_q;
	logic [CW-1:0]          cy_q;
	mcr_pkg::pts_t          pts_q;

	logic [mcr_pkg::RADIUS_BITS-1:0] r_sat;
	logic signed [DW-1:0]   two_x;
	logic signed [DW-1:0]   two_y;
	logic signed [DW-1:0]   inc_neg;
	logic signed [DW-1:0]   inc_pos;
	logic [CW-1:0]          xe;
	logic [CW-1:0]          ye;
	logic                   more;

	assign r_sat = (req.radius > mcr_pkg::MAX_RADIUS) ? mcr_pkg::MAX_RADIUS : req.radius;

	assign two_x   = signed'({{(DW-SW-1){1'b0}}, x_q, 1'b0});
	assign two_y   = signed'({{(DW-SW-1){1'b0}}, y_q, 1'b0});
	assign inc_neg = two_x + DW'(3);
	assign inc_pos = two_x - two_y + DW'(5);

	assign more = (y_q > x_q) && (x_q < mcr_pkg::MAX_SETS);
	assign status.more = more;

	assign xe = CW'(x_q);
	assign ye = CW'(y_q);

	// Step registers: load a new circle or advance one octant step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			d_q  <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.load) begin
			x_q  <= '0;
			y_q  <= SW'(r_sat);
			d_q  <= DW'(1) - signed'(DW'(r_sat));
			cx_q <= CW'(req.center_x);
			cy_q <= CW'(req.center_y);
		end else if (cmd.emit && more) begin
			if (d_q < 0) begin
				d_q <= d_q + inc_neg;
			end else begin
				d_q <= d_q + inc_pos;
				y_q <= y_q - SW'(1);
			end
			x_q <= x_q + SW'(1);
		end
	end

	// Output register: the eight mirrored points of (x, y)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cmd.emit) begin
			pts_q.point_0 <= {cx_q + xe, cy_q + ye};
			pts_q.point_1 <= {cx_q - xe, cy_q + ye};
			pts_q.point_2 <= {cx_q + xe, cy_q - ye};
			pts_q.point_3 <= {cx_q - xe, cy_q - ye};
			pts_q.point_4 <= {cx_q + ye, cy_q + xe};
			pts_q.point_5 <= {cx_q - ye, cy_q + xe};
			pts_q.point_6 <= {cx_q + ye, cy_q - xe};
			pts_q.point_7 <= {cx_q - ye, cy_q - xe};
			pts_q.last    <= !more;
		end
	end

	assign pts = pts_q;

	a_step_x: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && more && !cmd.load) |=> (x_q == $past(x_q) + SW'(1)))
		else $error("x did not advance on a loop step");

	a_y_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && more && !cmd.load && d_q < 0) |=> (y_q == $past(y_q)))
		else $error("y moved on a negative decision");

	a_load_x: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (x_q == '0))
		else $error("x not cleared on circle load");

endmodule

FILE: hw/rtl/mcr_ctrl.sv
module mcr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                pts_valid,
	input  logic                pts_stall,
	input  mcr_pkg::dp_status_t status,
	output mcr_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !out_valid_q || !pts_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign cmd.load = accept;
	assign cmd.emit = (state_q == ST_RUN) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.emit && !status.more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!pts_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pts_valid = out_valid_q;

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN))
		else $error("accepted request did not start a circle");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted set not presented");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !status.more) |=> (state_q == ST_IDLE))
		else $error("controller stayed busy after the closing set");

endmodule

FILE: hw/rtl/midpoint_circle_rasterizer_top.sv
// First set: the accepted request loads the step registers, then the first emit writes
//   the output register. Throughput: one point set per cycle while the output is not
//   stalled; a circle of n loop sets gives n + 1 sets, the last one the closing set.
// The step loop of the datapath (one decision update per loop set) sets this rate.
// The next request is taken once the closing set is in the output register.
// Reset (arst_n low, asynchronous): controller goes idle and the output is emptied.
module midpoint_circle_rasterizer_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mcr_pkg::req_t  req,
	output logic           pts_valid,
	input  logic           pts_stall,
	output mcr_pkg::pts_t  pts
);

	// Command and status between sequencer and step datapath
	mcr_pkg::dp_cmd_t    cmd;
	mcr_pkg::dp_status_t status;

	// Sequencer: take one request, then advance one set per free output slot
	mcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.pts_valid (pts_valid),
		.pts_stall (pts_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: decision variable, step counters, held center, point mirror
	mcr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.pts    (pts)
	);

endmodule
